// ===== rtl/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg : shared types, constants and helpers for the include scanner
// Holds the one-hot parse mode encoding, the character codes the scanner
// looks for and the character-class functions used by the mode logic.
// ----------------------------------------------------------------------------
package ids_pkg;

  typedef enum logic [16:0] {
    MD_DEFAULT = 17'h00001,
    MD_STRING  = 17'h00002,
    MD_ESCAPE  = 17'h00004,
    MD_SLASH   = 17'h00008,
    MD_COMMENT = 17'h00010,
    MD_STAR    = 17'h00020,
    MD_HASH    = 17'h00040,
    MD_KW_I    = 17'h00080,
    MD_KW_N    = 17'h00100,
    MD_KW_C    = 17'h00200,
    MD_KW_L    = 17'h00400,
    MD_KW_U    = 17'h00800,
    MD_KW_D    = 17'h01000,
    MD_KW_E    = 17'h02000,
    MD_BLANK2  = 17'h04000,
    MD_OPEN    = 17'h08000,
    MD_NAME    = 17'h10000
  } parse_mode_t;

  // Outcome of scanning one byte
  typedef struct packed {
    parse_mode_t mode_next;
    logic        emit;
    logic [7:0]  out_char;
    logic        name_end;
  } step_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_name_byte(input logic [7:0] c);
    logic lower, upper, digit;
    lower = (c >= "a") && (c <= "z");
    upper = (c >= "A") && (c <= "Z");
    digit = (c >= "0") && (c <= "9");
    return lower || upper || digit || (c == CH_SLASH) || (c == CH_USCORE) ||
           (c == CH_DOT);
  endfunction

  // Default-mode reaction to a byte
  function automatic parse_mode_t default_next(input logic [7:0] c);
    parse_mode_t m;
    if (c == CH_QUOTE) begin
      m = MD_STRING;
    end else if (c == CH_SLASH) begin
      m = MD_SLASH;
    end else if (c == CH_HASH) begin
      m = MD_HASH;
    end else begin
      m = MD_DEFAULT;
    end
    return m;
  endfunction

  function automatic parse_mode_t comment_next(input logic [7:0] c);
    return (c == CH_STAR) ? MD_STAR : MD_COMMENT;
  endfunction

  // Opening delimiter of a file name, or fall back to default scanning
  function automatic parse_mode_t open_next(input logic [7:0] c);
    return ((c == CH_QUOTE) || (c == CH_LT)) ? MD_NAME : default_next(c);
  endfunction

endpackage

// ===== rtl/ids_mode_logic.sv =====
// ----------------------------------------------------------------------------
// ids_mode_logic : next-mode and result logic for one source byte
// Folds the re-examination of a byte after a mismatch into one decision,
// so each byte is resolved in one combinational pass.
// ----------------------------------------------------------------------------
module ids_mode_logic import ids_pkg::*; (
  input  parse_mode_t mode,
  input  logic [7:0]  in_char,
  input  logic        file_start,
  output step_t       step
);

  parse_mode_t mode_eff;

  assign mode_eff = file_start ? MD_DEFAULT : mode;

  always_comb begin
    step.mode_next = default_next(in_char);
    step.emit      = 1'b0;
    step.out_char  = in_char;
    step.name_end  = 1'b0;
    unique case (mode_eff)
      MD_DEFAULT: step.mode_next = default_next(in_char);
      MD_STRING: begin
        if (in_char == CH_QUOTE) begin
          step.mode_next = MD_DEFAULT;
        end else if (in_char == CH_BSLASH) begin
          step.mode_next = MD_ESCAPE;
        end else begin
          step.mode_next = MD_STRING;
        end
      end
      MD_ESCAPE:  step.mode_next = MD_STRING;
      MD_SLASH:   step.mode_next = (in_char == CH_STAR) ? MD_COMMENT
                                                        : default_next(in_char);
      MD_COMMENT: step.mode_next = comment_next(in_char);
      MD_STAR:    step.mode_next = (in_char == CH_SLASH) ? MD_DEFAULT
                                                         : comment_next(in_char);
      MD_HASH: begin
        if (is_blank(in_char)) begin
          step.mode_next = MD_HASH;
        end else begin
          step.mode_next = (in_char == "i") ? MD_KW_N : default_next(in_char);
        end
      end
      MD_KW_I: step.mode_next = (in_char == "i") ? MD_KW_N : default_next(in_char);
      MD_KW_N: step.mode_next = (in_char == "n") ? MD_KW_C : default_next(in_char);
      MD_KW_C: step.mode_next = (in_char == "c") ? MD_KW_L : default_next(in_char);
      MD_KW_L: step.mode_next = (in_char == "l") ? MD_KW_U : default_next(in_char);
      MD_KW_U: step.mode_next = (in_char == "u") ? MD_KW_D : default_next(in_char);
      MD_KW_D: step.mode_next = (in_char == "d") ? MD_KW_E : default_next(in_char);
      MD_KW_E: step.mode_next = (in_char == "e") ? MD_BLANK2 : default_next(in_char);
      MD_BLANK2: step.mode_next = is_blank(in_char) ? MD_BLANK2 : open_next(in_char);
      MD_OPEN:   step.mode_next = open_next(in_char);
      MD_NAME: begin
        step.emit = 1'b1;
        if (is_name_byte(in_char)) begin
          step.mode_next = MD_NAME;
        end else begin
          step.mode_next = MD_DEFAULT;
          step.out_char  = CH_NL;
          step.name_end  = 1'b1;
        end
      end
      default: step.mode_next = default_next(in_char);
    endcase
  end

endmodule

// ===== rtl/include_directive_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// include_directive_scanner_unit : include file name extractor for C source
// A byte accepted into the input stage is resolved by the mode logic; its
//   result, if any, is held in the output register from then on.
// Throughput: one byte per clock unless a result byte stalls on a full output.
// Reset (rst, synchronous): parse mode to default scanning, both stages empty.
// ----------------------------------------------------------------------------
module include_directive_scanner_unit import ids_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       file_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       name_end
);

  // Input stage: one captured beat waiting to be scanned
  logic        s_valid;
  logic [7:0]  s_char;
  logic        s_file_start;

  // Scanner state
  parse_mode_t mode;

  step_t       step;
  logic        stall;
  logic        advance;

  ids_mode_logic u_mode_logic (
    .mode       (mode),
    .in_char    (s_char),
    .file_start (s_file_start),
    .step       (step)
  );

  // Hold the input stage only when its byte yields a result and the output
  // register still holds an untaken beat; bytes that give no result always
  // advance, so comment and string text streams through regardless.
  assign stall    = s_valid && step.emit && out_valid && !out_ready;
  assign advance  = s_valid && !stall;
  assign in_ready = !stall;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
      mode      <= MD_DEFAULT;
    end else begin
      if (in_ready) begin
        s_valid <= in_valid;
      end
      if (advance) begin
        mode <= step.mode_next;
      end
      if (advance && step.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: capture the incoming beat and the produced result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_char       <= in_char;
      s_file_start <= file_start;
    end
    if (advance && step.emit) begin
      out_char <= step.out_char;
      name_end <= step.name_end;
    end
  end

endmodule
